@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define KSHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition leads to another one in the next cycle.
`define KSHT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ksht_pkg.sv @@
`default_nettype none

package ksht_pkg;

  localparam int PID_W    = 8;
  localparam int SAMPLE_W = 64;
  localparam int ENT_W    = 3;
  localparam int AGE_W    = 6;
  localparam int SLOT_W   = 7;

  typedef enum logic [1:0] {
    FN_RECORD  = 2'd0,
    FN_RESET   = 2'd1,
    FN_LATEST  = 2'd2,
    FN_ORDERED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_META = 4'b0100,
    S_DATA = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/ksht_ram.sv @@
`default_nettype none

module ksht_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/ksht_key_cam.sv @@
`default_nettype none

module ksht_key_cam #(
  parameter int KEYS = 8,
  parameter int EW   = 3,
  parameter int CW   = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       lookup_en,
  input  wire logic [ksht_pkg::PID_W-1:0] lookup_key,
  input  wire logic [CW-1:0]              key_count,
  input  wire logic                       wr_en,
  input  wire logic [EW-1:0]              wr_idx,
  input  wire logic [ksht_pkg::PID_W-1:0] wr_key,
  output logic                            hit,
  output logic      [EW-1:0]              hit_idx
);

  logic [ksht_pkg::PID_W-1:0] keys_r [KEYS];
  logic [KEYS-1:0]            match_r;
  logic [KEYS-1:0]            match_nxt;

  // Only entries below the fill count take part in the compare.
  always_comb begin
    for (int i = 0; i < KEYS; i++) begin
      match_nxt[i] = (keys_r[i] == lookup_key) && (CW'(i) < key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
    end else if (lookup_en) begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_r[wr_idx] <= wr_key;
    end
  end

  always_comb begin
    hit     = |match_r;
    hit_idx = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = EW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/keyed_sample_history_table_core.sv @@
// Keyed sample history table.
// Input channel (in_valid/in_ready) carries one command per transfer: record a
// 64-bit sample under an 8-bit key, clear the table, fetch the newest sample
// of a key, or read an entry's history by age (age 0 is the oldest sample).
// Result channel (out_valid/out_ready) returns exactly one result per command
// with a status, the sample read and, for ordered reads, the physical slot.
// Each result passes through these steps: the key compare is registered at the
// accepting edge, then S_FIND reads the entry's pointer and fill count from the
// metadata memory, S_META accesses the sample memory and S_DATA loads the
// registered read data into the output register.
// in_ready is high only while no command is in progress; a finished result
// waiting on out_ready does not hold off the next command, but that command
// stalls in its last step until the output register is free.
// Reset (rst_n low, synchronous) empties the table and the output register;
// no memory clearing pass is needed, as entries beyond the key count read as
// empty and every sample read is bounded by the entry's fill count.
`default_nettype none

`include "assert_macros.svh"

module keyed_sample_history_table_core #(
  parameter int KEYS  = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic [ksht_pkg::PID_W-1:0]    in_pid,
  input  wire logic [ksht_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic [ksht_pkg::ENT_W-1:0]    in_entry_index,
  input  wire logic [ksht_pkg::AGE_W-1:0]    in_age_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    out_status,
  output logic      [ksht_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic      [ksht_pkg::SLOT_W-1:0]   out_slot_out
);

  localparam int EW   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CW   = $clog2(KEYS + 1);
  localparam int SW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int MW   = SW + FW;
  localparam int IW   = (CW > ksht_pkg::ENT_W) ? CW : ksht_pkg::ENT_W;
  localparam int AGW  = (FW > ksht_pkg::AGE_W) ? FW : ksht_pkg::AGE_W;
  localparam int SUMW = ((SW > ksht_pkg::AGE_W) ? SW : ksht_pkg::AGE_W) + 1;

  ksht_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    key_count_r, key_count_nxt;
  logic             out_valid_r, out_valid_nxt;

  ksht_pkg::func_t              func_r;
  logic [ksht_pkg::PID_W-1:0]   pid_r;
  logic [ksht_pkg::SAMPLE_W-1:0] sample_r;
  logic [ksht_pkg::ENT_W-1:0]   ent_r;
  logic [ksht_pkg::AGE_W-1:0]   age_r;
  logic [EW-1:0]                entry_r;
  logic                         hit_r;
  ksht_pkg::status_t            res_status_r;
  logic [ksht_pkg::SLOT_W-1:0]  res_slot_r;
  logic                         res_rd_r;
  ksht_pkg::status_t            out_status_r;
  logic [ksht_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [ksht_pkg::SLOT_W-1:0]  out_slot_r;

  logic          accept;
  logic          cam_hit;
  logic [EW-1:0] cam_idx;
  logic          cam_wr;
  logic [EW-1:0] entry_sel;

  logic          meta_re, meta_we;
  logic [MW-1:0] meta_rdata;
  logic [MW-1:0] meta_wdata;

  logic                          smp_re, smp_we;
  logic [EW+SW-1:0]              smp_addr;
  logic [ksht_pkg::SAMPLE_W-1:0] smp_rdata;

  logic                        meta_valid;
  logic [SW-1:0]               cur_wp, wp_inc, wp_dec, start_slot, ord_slot, acc_slot;
  logic [FW-1:0]               cur_fill, fill_inc;
  logic [SUMW-1:0]             age_sum;
  logic                        out_of_range, table_full, load_out;
  ksht_pkg::status_t           status_nxt;
  logic [ksht_pkg::SLOT_W-1:0] slot_nxt;
  logic                        rd_nxt;

  assign in_ready = (state_r == ksht_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ksht_pkg::S_DATA) && (!out_valid_r || out_ready);

  ksht_key_cam #(
    .KEYS (KEYS),
    .EW   (EW),
    .CW   (CW)
  ) u_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_en  (accept),
    .lookup_key (in_pid),
    .key_count  (key_count_r),
    .wr_en      (cam_wr),
    .wr_idx     (entry_r),
    .wr_key     (pid_r),
    .hit        (cam_hit),
    .hit_idx    (cam_idx)
  );

  ksht_ram #(
    .W  (MW),
    .AW (EW)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (entry_r),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (entry_sel),
    .rdata (meta_rdata)
  );

  ksht_ram #(
    .W  (ksht_pkg::SAMPLE_W),
    .AW (EW + SW)
  ) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_addr),
    .wdata (sample_r),
    .re    (smp_re),
    .raddr (smp_addr),
    .rdata (smp_rdata)
  );

  // A new key takes the entry at the current key count.
  always_comb begin
    if (func_r == ksht_pkg::FN_ORDERED) begin
      entry_sel = EW'(ent_r);
    end else if (cam_hit) begin
      entry_sel = cam_idx;
    end else begin
      entry_sel = EW'(key_count_r);
    end
  end

  // Entries at or beyond the key count have not been used since the last
  // clear, so their metadata reads as zero whatever the memory holds.
  always_comb begin
    meta_valid   = (CW'(entry_r) < key_count_r);
    cur_wp       = meta_valid ? meta_rdata[MW-1:FW] : '0;
    cur_fill     = meta_valid ? meta_rdata[FW-1:0] : '0;
    wp_inc       = (cur_wp == SW'(DEPTH - 1)) ? '0 : cur_wp + 1'b1;
    wp_dec       = (cur_wp == '0) ? SW'(DEPTH - 1) : cur_wp - 1'b1;
    fill_inc     = (cur_fill == FW'(DEPTH)) ? cur_fill : cur_fill + 1'b1;
    start_slot   = (cur_fill == FW'(DEPTH)) ? cur_wp : '0;
    age_sum      = SUMW'(start_slot) + SUMW'(age_r);
    ord_slot     = (age_sum >= SUMW'(DEPTH)) ? SW'(age_sum - SUMW'(DEPTH)) : SW'(age_sum);
    out_of_range = (IW'(ent_r) >= IW'(key_count_r)) || (AGW'(age_r) >= AGW'(cur_fill));
    table_full   = !hit_r && (key_count_r == CW'(KEYS));
  end

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    out_valid_nxt = out_valid_r;
    meta_re       = 1'b0;
    meta_we       = 1'b0;
    meta_wdata    = {wp_inc, fill_inc};
    smp_re        = 1'b0;
    smp_we        = 1'b0;
    acc_slot      = cur_wp;
    cam_wr        = 1'b0;
    status_nxt    = ksht_pkg::ST_OK;
    slot_nxt      = '0;
    rd_nxt        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ksht_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ksht_pkg::S_FIND;
        end
      end
      ksht_pkg::S_FIND: begin
        meta_re = 1'b1;
        if (func_r == ksht_pkg::FN_RESET) begin
          key_count_nxt = '0;
        end
        state_nxt = ksht_pkg::S_META;
      end
      ksht_pkg::S_META: begin
        case (func_r)
          ksht_pkg::FN_RECORD: begin
            if (table_full) begin
              status_nxt = ksht_pkg::ST_FULL;
            end else begin
              smp_we  = 1'b1;
              meta_we = 1'b1;
              if (!hit_r) begin
                cam_wr        = 1'b1;
                key_count_nxt = key_count_r + 1'b1;
              end
            end
          end
          ksht_pkg::FN_LATEST: begin
            acc_slot = wp_dec;
            if (!hit_r || (cur_fill == '0)) begin
              status_nxt = ksht_pkg::ST_NOTFOUND;
            end else begin
              smp_re = 1'b1;
              rd_nxt = 1'b1;
            end
          end
          ksht_pkg::FN_ORDERED: begin
            acc_slot = ord_slot;
            if (out_of_range) begin
              status_nxt = ksht_pkg::ST_RANGE;
              slot_nxt   = ksht_pkg::SLOT_W'(DEPTH);
            end else begin
              smp_re   = 1'b1;
              rd_nxt   = 1'b1;
              slot_nxt = ksht_pkg::SLOT_W'(ord_slot);
            end
          end
          default: begin
            status_nxt = ksht_pkg::ST_OK;
          end
        endcase
        state_nxt = ksht_pkg::S_DATA;
      end
      ksht_pkg::S_DATA: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ksht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ksht_pkg::S_IDLE;
      end
    endcase
  end

  assign smp_addr = {entry_r, acc_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksht_pkg::S_IDLE;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= ksht_pkg::func_t'(in_func);
      pid_r    <= in_pid;
      sample_r <= in_sample_value;
      ent_r    <= in_entry_index;
      age_r    <= in_age_index;
    end
    if (state_r == ksht_pkg::S_FIND) begin
      entry_r <= entry_sel;
      hit_r   <= cam_hit;
    end
    if (state_r == ksht_pkg::S_META) begin
      res_status_r <= status_nxt;
      res_slot_r   <= slot_nxt;
      res_rd_r     <= rd_nxt;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_sample_r <= res_rd_r ? smp_rdata : '0;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_sample_out = out_sample_r;
  assign out_slot_out   = out_slot_r;

  `KSHT_ASSERT(a_count_bound, key_count_r <= CW'(KEYS), "key count beyond table size")
  `KSHT_ASSERT_NEXT(a_accept_find, in_valid && in_ready,
                    state_r == ksht_pkg::S_FIND,
                    "accepted command did not start the key search")
  `KSHT_ASSERT(a_full_status,
               ((state_r == ksht_pkg::S_DATA) && (res_status_r == ksht_pkg::ST_FULL))
               |-> (key_count_r == CW'(KEYS)),
               "table-full status with free entries")
  `KSHT_ASSERT_NEXT(a_count_step, 1'b1,
                    (key_count_r == $past(key_count_r)) ||
                    (key_count_r == $past(key_count_r) + 1'b1) || (key_count_r == '0),
                    "key count moved by more than one")

endmodule

`default_nettype wire
